/* sv/dlat_pkg.sv */
// Shared constants and decay factor table for the decaying load average tracker.
package dlat_pkg;

  localparam int unsigned TimeW       = 64;
  localparam int unsigned SumW        = 64;
  localparam int unsigned WeightW     = 20;
  localparam int unsigned AvgShift    = 10;
  localparam int unsigned AvgW        = SumW - AvgShift;
  localparam int unsigned PeriodShift = 20;
  localparam int unsigned PeriodsW    = TimeW - PeriodShift;
  localparam int unsigned ContribW    = 32;
  localparam int unsigned FactorW     = 32;
  localparam int unsigned HalfW       = SumW / 2;
  localparam int unsigned DecayDepth  = 32;
  localparam int unsigned DecayIdxW   = $clog2(DecayDepth);
  localparam logic [TimeW-1:0] MinElapsed = TimeW'(1024);

  // Per-period decay factors (about 0.9785^n) in 0.32 fixed point.
  localparam logic [FactorW-1:0] DecayFactor [DecayDepth] = '{
    32'd4294967295, 32'd4202502893, 32'd4112015082, 32'd4023467471,
    32'd3936824108, 32'd3852049516, 32'd3769108719, 32'd3687967116,
    32'd3608590510, 32'd3530945084, 32'd3454997395, 32'd3380714361,
    32'd3308063242, 32'd3237011622, 32'd3167527318, 32'd3099578339,
    32'd3033133035, 32'd2968159990, 32'd2904627911, 32'd2842505706,
    32'd2781762483, 32'd2722367543, 32'd2664290382, 32'd2607500778,
    32'd2551968705, 32'd2497664319, 32'd2444558034, 32'd2392620520,
    32'd2341822704, 32'd2292135767, 32'd2243531141, 32'd2195980508
  };

endpackage

/* sv/decaying_load_average_tracker_top.sv */
// Top level of the decaying load average tracker.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | now_time_i, is_running_i, is_runnable_i,
//          |                         | load_weight_i
//  out     | out_valid_o/out_stall_i | updated_o, load_average_o,
//          |                         | runnable_average_o, util_average_o
//
// One item per cycle unless the output stalls; results leave via the output register.
// The input register feeds the decay multipliers and adders, which update the sums and
// load the output register in the same cycle.
// rst_ni clears the timestamp, the sums and both valid flags.
// A stalled output holds the item in the input register; in_stall_o rises only then.
module decaying_load_average_tracker_top import dlat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [TimeW-1:0]   now_time_i,
  input  logic               is_running_i,
  input  logic               is_runnable_i,
  input  logic [WeightW-1:0] load_weight_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               updated_o,
  output logic [AvgW-1:0]    load_average_o,
  output logic [AvgW-1:0]    runnable_average_o,
  output logic [AvgW-1:0]    util_average_o
);

  logic               s1_valid_q;
  logic [TimeW-1:0]   s1_now_q;
  logic               s1_running_q;
  logic               s1_runnable_q;
  logic [WeightW-1:0] s1_weight_q;

  logic               out_valid_q;
  logic               updated_q;
  logic [AvgW-1:0]    load_mean_q, runnable_mean_q, util_mean_q;

  logic [TimeW-1:0]   last_update_q;
  logic [SumW-1:0]    load_total_q, runnable_total_q, util_total_q;
  logic [SumW-1:0]    load_total_d, runnable_total_d, util_total_d;

  logic               out_free;
  logic               advance;
  logic               in_take;
  logic [TimeW-1:0]   elapsed;
  logic               do_update;
  logic [PeriodsW-1:0] periods;
  logic [PeriodShift+WeightW-1:0] part_prod;
  logic [ContribW-1:0] contrib;
  logic [SumW-1:0]    load_dec, runnable_dec, util_dec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign elapsed   = s1_now_q - last_update_q;
  assign do_update = elapsed >= MinElapsed;
  assign periods   = elapsed[TimeW-1:PeriodShift];
  assign part_prod = elapsed[PeriodShift-1:0] * s1_weight_q;
  assign contrib   = part_prod[ContribW-1:0];

  dlat_decay u_decay_load (
    .sum_i     (load_total_q),
    .periods_i (periods),
    .sum_o     (load_dec)
  );

  dlat_decay u_decay_runnable (
    .sum_i     (runnable_total_q),
    .periods_i (periods),
    .sum_o     (runnable_dec)
  );

  dlat_decay u_decay_util (
    .sum_i     (util_total_q),
    .periods_i (periods),
    .sum_o     (util_dec)
  );

  always_comb begin
    load_total_d     = load_total_q;
    runnable_total_d = runnable_total_q;
    util_total_d     = util_total_q;
    if (do_update) begin
      load_total_d     = load_dec + SumW'(contrib);
      runnable_total_d = s1_runnable_q ? runnable_dec + SumW'(contrib) : runnable_dec;
      util_total_d     = s1_running_q ? util_dec + SumW'(contrib) : util_dec;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q      <= now_time_i;
      s1_running_q  <= is_running_i;
      s1_runnable_q <= is_runnable_i;
      s1_weight_q   <= load_weight_i;
    end
  end

  // Tracker state: advance once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_update_q    <= '0;
      load_total_q     <= '0;
      runnable_total_q <= '0;
      util_total_q     <= '0;
    end else if (advance) begin
      if (do_update) begin
        last_update_q <= s1_now_q;
      end
      load_total_q     <= load_total_d;
      runnable_total_q <= runnable_total_d;
      util_total_q     <= util_total_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      updated_q       <= do_update;
      load_mean_q     <= load_total_d[SumW-1:AvgShift];
      runnable_mean_q <= runnable_total_d[SumW-1:AvgShift];
      util_mean_q     <= util_total_d[SumW-1:AvgShift];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign updated_o          = updated_q;
  assign load_average_o     = load_mean_q;
  assign runnable_average_o = runnable_mean_q;
  assign util_average_o     = util_mean_q;

endmodule

/* sv/dlat_decay.sv */
// Decay of one 64-bit sum by a whole number of periods.
module dlat_decay import dlat_pkg::*; (
  input  logic [SumW-1:0]     sum_i,
  input  logic [PeriodsW-1:0] periods_i,
  output logic [SumW-1:0]     sum_o
);

  logic [FactorW-1:0]      factor;
  logic [HalfW+FactorW-1:0] hi_prod;
  logic [HalfW+FactorW-1:0] lo_prod;
  logic [SumW-1:0]         scaled;

  assign factor  = DecayFactor[periods_i[DecayIdxW-1:0]];
  assign hi_prod = sum_i[SumW-1:HalfW] * factor;
  assign lo_prod = sum_i[HalfW-1:0] * factor;
  // Keep the full product: floor(sum * factor / 2^32).
  assign scaled  = SumW'(hi_prod) + SumW'(lo_prod[HalfW+FactorW-1:FactorW]);

  always_comb begin
    if (periods_i == '0) begin
      sum_o = sum_i;
    end else if (periods_i >= PeriodsW'(DecayDepth)) begin
      sum_o = '0;
    end else begin
      sum_o = scaled;
    end
  end

endmodule

/* sim/decaying_load_average_tracker_top_test.sv */
// Self-checking testbench for the decaying load average tracker top level.
`timescale 1ns / 1ps

module decaying_load_average_tracker_top_test;
  import dlat_pkg::*;

  localparam int unsigned RandomSamples = 750;
  localparam int unsigned TailItems     = 60;
  localparam int unsigned LongHoldAt    = 420;
  localparam int unsigned LongHoldLen   = 150;
  localparam int unsigned MaxReports    = 10;
  localparam logic [TimeW-1:0]   PeriodLen = TimeW'(1) << PeriodShift;
  localparam logic [WeightW-1:0] WeightMax = '1;

  // 0.32 fixed point decay per whole period.
  localparam logic [31:0] DecayRatio [32] = '{
    32'd4294967295, 32'd4202502893, 32'd4112015082, 32'd4023467471,
    32'd3936824108, 32'd3852049516, 32'd3769108719, 32'd3687967116,
    32'd3608590510, 32'd3530945084, 32'd3454997395, 32'd3380714361,
    32'd3308063242, 32'd3237011622, 32'd3167527318, 32'd3099578339,
    32'd3033133035, 32'd2968159990, 32'd2904627911, 32'd2842505706,
    32'd2781762483, 32'd2722367543, 32'd2664290382, 32'd2607500778,
    32'd2551968705, 32'd2497664319, 32'd2444558034, 32'd2392620520,
    32'd2341822704, 32'd2292135767, 32'd2243531141, 32'd2195980508
  };

  typedef struct {
    logic [TimeW-1:0]   stamp;
    logic               running;
    logic               runnable;
    logic [WeightW-1:0] weight;
    bit                 wait_drain;
  } load_sample_t;

  typedef struct {
    logic            upd;
    logic [AvgW-1:0] load_mean;
    logic [AvgW-1:0] runnable_mean;
    logic [AvgW-1:0] util_mean;
  } average_set_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [TimeW-1:0]   now_time_i = '0;
  logic               is_running_i = 1'b0;
  logic               is_runnable_i = 1'b0;
  logic [WeightW-1:0] load_weight_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               updated_o;
  logic [AvgW-1:0]    load_average_o;
  logic [AvgW-1:0]    runnable_average_o;
  logic [AvgW-1:0]    util_average_o;

  decaying_load_average_tracker_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .now_time_i         (now_time_i),
    .is_running_i       (is_running_i),
    .is_runnable_i      (is_runnable_i),
    .load_weight_i      (load_weight_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .updated_o          (updated_o),
    .load_average_o     (load_average_o),
    .runnable_average_o (runnable_average_o),
    .util_average_o     (util_average_o)
  );

  load_sample_t pending_samples[$];
  average_set_t expected_averages[$];
  load_sample_t offered_sample;

  // Tracker state as the block should hold it.
  logic [TimeW-1:0] last_stamp = '0;
  logic [SumW-1:0]  load_acc = '0;
  logic [SumW-1:0]  runnable_acc = '0;
  logic [SumW-1:0]  util_acc = '0;

  // Last stored timestamp as seen while building stimulus.
  logic [TimeW-1:0] plan_stamp = '0;

  bit in_taken = 1'b0;
  int total_samples = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int send_gap_left = 0;
  int send_calm_left = 0;
  int recv_gap_left = 0;
  int recv_calm_left = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;

  function automatic logic [SumW-1:0] decay_sum(logic [SumW-1:0] value,
                                                logic [TimeW-1:0] periods);
    logic [63:0] ratio;
    if (periods >= 64'd32) return '0;
    ratio = {32'b0, DecayRatio[periods[4:0]]};
    return ({32'b0, value[63:32]} * ratio) + (({32'b0, value[31:0]} * ratio) >> 32);
  endfunction

  function automatic average_set_t advance_tracker(load_sample_t s);
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] periods;
    logic [SumW-1:0]  contrib;
    average_set_t     r;
    elapsed = s.stamp - last_stamp;
    r.upd = 1'b0;
    if (elapsed >= 64'd1024) begin
      periods = elapsed >> PeriodShift;
      last_stamp = s.stamp;
      if (periods != 0) begin
        load_acc     = decay_sum(load_acc, periods);
        runnable_acc = decay_sum(runnable_acc, periods);
        util_acc     = decay_sum(util_acc, periods);
      end
      contrib = (64'(elapsed[PeriodShift-1:0]) * 64'(s.weight)) & 64'hFFFF_FFFF;
      if (s.runnable) runnable_acc = runnable_acc + contrib;
      if (s.running) util_acc = util_acc + contrib;
      load_acc = load_acc + contrib;
      r.upd = 1'b1;
    end
    r.load_mean     = load_acc[SumW-1:AvgShift];
    r.runnable_mean = runnable_acc[SumW-1:AvgShift];
    r.util_mean     = util_acc[SumW-1:AvgShift];
    return r;
  endfunction

  task automatic queue_sample(logic [TimeW-1:0] stamp, bit running, bit runnable,
                              logic [WeightW-1:0] weight, bit wait_drain);
    load_sample_t s;
    s.stamp      = stamp;
    s.running    = running;
    s.runnable   = runnable;
    s.weight     = weight;
    s.wait_drain = wait_drain;
    pending_samples.push_back(s);
    if (stamp - plan_stamp >= 64'd1024) plan_stamp = stamp;
  endtask

  function automatic logic [TimeW-1:0] pick_stamp();
    logic [TimeW-1:0] step;
    case ($urandom_range(0, 19))
      0, 1, 2:             step = 64'($urandom_range(0, 1023));
      3, 4, 5, 6, 7, 8, 9: step = 64'($urandom_range(1024, PeriodLen - 1));
      10, 11, 12, 13, 14, 15:
        step = (64'($urandom_range(1, 40)) << PeriodShift) |
               64'($urandom_range(0, PeriodLen - 1));
      16:      step = {$urandom, $urandom};
      17:      step = -64'($urandom_range(1, 1 << 22));
      default: return {$urandom, $urandom};
    endcase
    return plan_stamp + step;
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WeightMax;
      default: return WeightW'($urandom_range(0, WeightMax));
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus: directed corners first, then random timestamps and weights.
  initial begin
    queue_sample(64'd0, 1, 1, WeightMax, 0);
    queue_sample(64'd1023, 1, 1, WeightMax, 0);
    queue_sample(64'd1024, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + PeriodLen - 1, 1, 0, WeightMax, 0);
    queue_sample(plan_stamp + 64'd921600, 0, 1, WeightMax, 0);
    queue_sample(plan_stamp + 64'd500000, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + PeriodLen, 1, 1, 20'hABCDE, 0);
    queue_sample(plan_stamp + 3 * PeriodLen + 64'd77777, 1, 0, 20'h12345, 0);
    queue_sample(plan_stamp + 64'd1000, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + 64'd700000, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + 31 * PeriodLen + 64'd12345, 0, 1, 20'h54321, 0);
    queue_sample(plan_stamp + 64'd600000, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + 32 * PeriodLen, 1, 1, 20'h55555, 0);
    queue_sample(plan_stamp + 64'd800000, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + 33 * PeriodLen + 64'd1, 1, 1, 20'hAAAAA, 0);
    queue_sample(plan_stamp + 64'd900000, 1, 1, WeightMax, 0);
    // clock going backwards
    queue_sample(plan_stamp - 64'd5000, 1, 0, WeightMax, 0);
    queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 20'h00001, 0);
    // wraps to an elapsed time of one unit
    queue_sample(64'd0, 1, 1, WeightMax, 0);
    queue_sample(64'd1024, 1, 1, 20'h80000, 0);
    queue_sample(plan_stamp + 64'd400000, 1, 1, '0, 0);
    queue_sample(64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 20'h5A5A5, 0);
    queue_sample(64'h5555_5555_5555_5555, 1, 1, WeightMax, 0);
    queue_sample(plan_stamp + 2 * PeriodLen + 64'd1023, 1, 1, WeightMax, 0);
    for (int i = 0; i < RandomSamples; i++) begin
      queue_sample(pick_stamp(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pick_weight(), i == 0 || i == 300);
    end
    total_samples = pending_samples.size();

    wait (rst_ni);
    while (pending_samples.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Sender: present the next item, hold it while stalled, idle in bursts.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_gap_left != 0) begin
        send_gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() == 0 ||
                   (pending_samples[0].wait_drain && expected_averages.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        offered_sample = pending_samples.pop_front();
        now_time_i    <= offered_sample.stamp;
        is_running_i  <= offered_sample.running;
        is_runnable_i <= offered_sample.runnable;
        load_weight_i <= offered_sample.weight;
        in_valid_i    <= 1'b1;
        if (pending_samples.size() > TailItems) begin
          if (send_calm_left != 0) begin
            send_calm_left--;
          end else begin
            case ($urandom_range(0, 9))
              0, 1:    send_gap_left = $urandom_range(1, 14);
              2:       send_calm_left = $urandom_range(10, 60);
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (results_seen >= total_samples - TailItems) begin
        out_stall_i <= 1'b0;
      end else if (recv_gap_left != 0) begin
        recv_gap_left--;
        out_stall_i <= 1'b1;
      end else if (recv_calm_left != 0) begin
        recv_calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            recv_gap_left = $urandom_range(0, 13);
            out_stall_i <= 1'b1;
          end
          2: begin
            recv_calm_left = $urandom_range(10, 60);
            out_stall_i <= 1'b0;
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!long_hold_done && samples_taken >= LongHoldAt) begin
      long_hold_done = 1'b1;
      long_hold_left = LongHoldLen;
    end else if (long_hold_left != 0) begin
      long_hold_left--;
    end
  end

  // Check each result against the oldest prediction, then predict the accepted item.
  always @(posedge clk_i) begin
    average_set_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_averages.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected item %0d: upd=%0d load=%h runnable=%h util=%h",
                     results_seen, updated_o, load_average_o, runnable_average_o,
                     util_average_o);
        end else begin
          want = expected_averages.pop_front();
          if (updated_o !== want.upd || load_average_o !== want.load_mean ||
              runnable_average_o !== want.runnable_mean ||
              util_average_o !== want.util_mean)
          begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("mismatch on item %0d: expected upd=%0d load=%h runnable=%h util=%h",
                       results_seen, want.upd, want.load_mean, want.runnable_mean,
                       want.util_mean);
              $display("                      actual upd=%0d load=%h runnable=%h util=%h",
                       updated_o, load_average_o, runnable_average_o, util_average_o);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        samples_taken++;
        expected_averages.push_back(advance_tracker(offered_sample));
      end
    end
  end

endmodule
